>>> design/ndt_pkg.sv
// ----------------------------------------------------------------------------
// ndt_pkg: shared types and constants of the transpose index generator
// Field widths, register indexes, reset values and the beat control word
// that travels down the cell chain.
// ----------------------------------------------------------------------------
package ndt_pkg;

  // Fixed field widths.
  localparam int IN_W         = 32;
  localparam int OUT_W        = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int RANK_W       = 4;
  localparam int DIM_W        = 16;
  localparam int AXIS_W       = 3;
  localparam int AXIS_ORDER_W = 24;
  localparam int NUM_PAIRS    = 4;

  // Quotient bits per output axis; a coordinate never exceeds a dimension size.
  localparam int DIGITS = DIM_W;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANK   = 3'd0,
    REG_DIMS_A = 3'd1,
    REG_DIMS_B = 3'd2,
    REG_DIMS_C = 3'd3,
    REG_DIMS_D = 3'd4,
    REG_AXIS   = 3'd5
  } cfg_reg_t;

  // Register reset values: rank one, unit sizes, identity permutation.
  localparam logic [RANK_W-1:0]       RANK_RST = 4'd1;
  localparam logic [CFG_DATA_W-1:0]   DIMS_RST = 32'h0001_0001;
  localparam logic [AXIS_ORDER_W-1:0] AXIS_RST = 24'hFA_C688;

  // Control word carried with each beat through the cell chain.
  typedef struct packed {
    logic valid;
    logic oor;
  } cell_ctl_t;

endpackage

>>> design/ndt_in_if.sv
// ----------------------------------------------------------------------------
// ndt_in_if: output index channel
// Carries one row-major output linear index per beat.
// ----------------------------------------------------------------------------
interface ndt_in_if;
  import ndt_pkg::*;

  logic            valid;
  logic            ready;
  logic [IN_W-1:0] out_index;

  modport source (output valid, output out_index, input ready);
  modport sink   (input valid, input out_index, output ready);
endinterface

>>> design/ndt_out_if.sv
// ----------------------------------------------------------------------------
// ndt_out_if: source index channel
// Carries one source linear index and its range flag per beat.
// ----------------------------------------------------------------------------
interface ndt_out_if;
  import ndt_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] source_index;
  logic             out_of_range;

  modport source (output valid, output source_index, output out_of_range, input ready);
  modport sink   (input valid, input source_index, input out_of_range, output ready);
endinterface

>>> design/ndt_cfg_if.sv
// ----------------------------------------------------------------------------
// ndt_cfg_if: configuration write channel
// Carries a register index and its write data per beat.
// ----------------------------------------------------------------------------
interface ndt_cfg_if;
  import ndt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/ndt_stride_seq.sv
// ----------------------------------------------------------------------------
// ndt_stride_seq: configuration registers and stride sweep
// Holds the shape registers and, after reset or any write, walks the axes
// from the innermost outward with one shared multiplier: first the input
// strides (latched per output axis as its coefficient), then the saturating
// output strides and the element count.
// ----------------------------------------------------------------------------
module ndt_stride_seq #(
  parameter int MAX_RANK   = 8,
  parameter int INDEX_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ndt_cfg_if.sink               cfg,
  output logic                  busy,
  output logic [INDEX_BITS:0]   div_stride [MAX_RANK],
  output logic [INDEX_BITS-1:0] coef       [MAX_RANK],
  output logic [INDEX_BITS:0]   elem_count
);
  import ndt_pkg::*;

  localparam int IB = INDEX_BITS;
  localparam int CW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam logic [CW-1:0]     CNT_LAST   = CW'(MAX_RANK - 1);
  localparam logic [IB:0]       ACC_ONE    = (IB+1)'(1);
  localparam logic [IB:0]       CAP        = {1'b1, {IB{1'b0}}};
  localparam logic [IB+DIM_W:0] CAP_EXT    = (IB+DIM_W+1)'(CAP);
  localparam logic [RANK_W-1:0] MAX_RANK_V = RANK_W'(MAX_RANK);
  localparam logic [DIM_W-1:0]  DIM_ONE    = DIM_W'(1);

  typedef enum logic {PH_IN, PH_OUT} phase_t;

  logic                                 cfg_fire;
  logic [RANK_W-1:0]                    rank_r;
  logic [NUM_PAIRS-1:0][CFG_DATA_W-1:0] dims_r;
  logic [AXIS_ORDER_W-1:0]              axis_r;
  logic [NUM_PAIRS*CFG_DATA_W-1:0]      dims_flat;

  phase_t         phase_r;
  logic           busy_r;
  logic [CW-1:0]  cnt_r;
  logic [IB:0]    acc_r;
  logic [IB:0]    acc_nxt;
  logic [IB:0]    div_stride_r [MAX_RANK];
  logic [IB-1:0]  coef_r       [MAX_RANK];
  logic [IB:0]    count_r;

  logic [RANK_W-1:0]  r_eff;
  logic               cnt_live;
  logic               sel_live;
  logic [AXIS_W-1:0]  sel_cnt;
  logic [AXIS_W-1:0]  dim_addr;
  logic [DIM_W-1:0]   dim_val;
  logic [DIM_W-1:0]   factor;
  logic [IB+DIM_W:0]  prod;
  logic [MAX_RANK-1:0] coef_hit;

  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid & cfg.ready;
  assign dims_flat = dims_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= RANK_RST;
      dims_r <= {NUM_PAIRS{DIMS_RST}};
      axis_r <= AXIS_RST;
    end else if (cfg_fire) begin
      case (cfg_reg_t'(cfg.index))
        REG_RANK:   rank_r    <= cfg.data[RANK_W-1:0];
        REG_DIMS_A: dims_r[0] <= cfg.data;
        REG_DIMS_B: dims_r[1] <= cfg.data;
        REG_DIMS_C: dims_r[2] <= cfg.data;
        REG_DIMS_D: dims_r[3] <= cfg.data;
        REG_AXIS:   axis_r    <= cfg.data[AXIS_ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective rank: zero counts as one, large values clip to the chain length.
  always_comb begin
    if (rank_r == '0) begin
      r_eff = RANK_W'(1);
    end else if (rank_r > MAX_RANK_V) begin
      r_eff = MAX_RANK_V;
    end else begin
      r_eff = rank_r;
    end
  end

  // One dimension read and one multiply per sweep cycle.
  always_comb begin
    cnt_live = RANK_W'(cnt_r) < r_eff;
    sel_cnt  = axis_r[AXIS_W*cnt_r +: AXIS_W];
    sel_live = RANK_W'(sel_cnt) < r_eff;
    dim_addr = (phase_r == PH_IN) ? AXIS_W'(cnt_r) : sel_cnt;
    dim_val  = dims_flat[DIM_W*dim_addr +: DIM_W];
    if (phase_r == PH_IN) begin
      factor = cnt_live ? dim_val : DIM_ONE;
    end else begin
      factor = (cnt_live && sel_live) ? dim_val : DIM_ONE;
    end
    prod = acc_r * factor;
    if (phase_r == PH_IN) begin
      acc_nxt = {1'b0, prod[IB-1:0]};
    end else begin
      acc_nxt = (prod > CAP_EXT) ? CAP : prod[IB:0];
    end
  end

  // An output axis takes the input stride of the live axis that it names.
  always_comb begin
    for (int i = 0; i < MAX_RANK; i++) begin
      coef_hit[i] = (AXIS_W'(cnt_r) == axis_r[AXIS_W*i +: AXIS_W]) && cnt_live &&
                    (RANK_W'(i) < r_eff);
    end
  end

  // Sweep sequencer: input strides, then output strides and element count.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_fire) begin
      busy_r  <= 1'b1;
      phase_r <= PH_IN;
      cnt_r   <= CNT_LAST;
      acc_r   <= ACC_ONE;
      for (int i = 0; i < MAX_RANK; i++) begin
        coef_r[i] <= '0;
      end
    end else if (busy_r) begin
      if (phase_r == PH_IN) begin
        for (int i = 0; i < MAX_RANK; i++) begin
          if (coef_hit[i]) begin
            coef_r[i] <= acc_r[IB-1:0];
          end
        end
        if (cnt_r == '0) begin
          phase_r <= PH_OUT;
          cnt_r   <= CNT_LAST;
          acc_r   <= ACC_ONE;
        end else begin
          cnt_r <= cnt_r - CW'(1);
          acc_r <= acc_nxt;
        end
      end else begin
        acc_r               <= acc_nxt;
        div_stride_r[cnt_r] <= acc_r;
        if (cnt_r == '0) begin
          count_r <= acc_nxt;
          busy_r  <= 1'b0;
        end else begin
          cnt_r <= cnt_r - CW'(1);
        end
      end
    end
  end

  assign busy       = busy_r;
  assign div_stride = div_stride_r;
  assign coef       = coef_r;
  assign elem_count = count_r;

endmodule

>>> design/ndt_cell.sv
// ----------------------------------------------------------------------------
// ndt_cell: one restoring-division step of the coordinate chain
// Tests one quotient bit of one output coordinate against the shifted output
// stride, removes it from the remainder and adds the matching multiple of the
// input stride to the running source index.
// ----------------------------------------------------------------------------
module ndt_cell #(
  parameter int INDEX_BITS = 32,
  parameter int SHIFT      = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  ndt_pkg::cell_ctl_t    ctl_i,
  input  logic [INDEX_BITS-1:0] rem_i,
  input  logic [INDEX_BITS-1:0] src_i,
  input  logic [INDEX_BITS:0]   stride,
  input  logic [INDEX_BITS-1:0] coef,
  output ndt_pkg::cell_ctl_t    ctl_o,
  output logic [INDEX_BITS-1:0] rem_o,
  output logic [INDEX_BITS-1:0] src_o
);
  import ndt_pkg::*;

  localparam int IB = INDEX_BITS;
  localparam int TW = IB + DIGITS;

  cell_ctl_t      ctl_r;
  logic [IB-1:0]  rem_r;
  logic [IB-1:0]  src_r;
  logic [TW-1:0]  trial;
  logic           take;
  logic [IB-1:0]  rem_nxt;
  logic [IB-1:0]  src_nxt;

  // Compare the remainder with the stride weighted by this quotient bit.
  always_comb begin
    trial   = TW'(stride) << SHIFT;
    take    = TW'(rem_i) >= trial;
    rem_nxt = take ? (rem_i - trial[IB-1:0]) : rem_i;
    src_nxt = take ? (src_i + (coef << SHIFT)) : src_i;
  end

  // Stage register; the whole chain holds while the output is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      src_r <= src_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign src_o = src_r;

endmodule

>>> design/nd_transpose_source_index.sv
// ----------------------------------------------------------------------------
// nd_transpose_source_index: source address generator for a tensor transpose
// Maps each row-major output linear index to the input linear index to read.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_bus  - register writes (rank, four dimension pairs, axis order); it is
//              always ready. Write only while no beat is in flight.
//   in_bus   - one output linear index per beat.
//   out_bus  - one source index and an out-of-range flag per beat, in order.
// Throughput is one beat per cycle while the receiver is ready and no stride
// sweep runs. The chain holds MAX_RANK*16 cells, one quotient bit of one
// output coordinate each, followed by the output register.
// After reset and after every configuration write, the stride sweep runs
// through its single multiplier, and in_bus.ready stays low until it
// finishes.
// When the receiver stalls, the output register and the whole chain hold and
// in_bus.ready drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module nd_transpose_source_index #(
  parameter int MAX_RANK   = 8,
  parameter int INDEX_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  ndt_in_if.sink    in_bus,
  ndt_out_if.source out_bus,
  ndt_cfg_if.sink   cfg_bus
);
  import ndt_pkg::*;

  localparam int IB     = INDEX_BITS;
  localparam int NCELLS = MAX_RANK * DIGITS;

  logic          busy;
  logic [IB:0]   div_stride [MAX_RANK];
  logic [IB-1:0] coef       [MAX_RANK];
  logic [IB:0]   elem_count;

  cell_ctl_t     ctl [NCELLS+1];
  logic [IB-1:0] rem [NCELLS+1];
  logic [IB-1:0] src [NCELLS+1];

  logic               advance;
  logic [IB+IN_W-1:0] idx_wide;
  logic [IB+IN_W:0]   idx_cmp;
  logic [IB+IN_W:0]   cnt_cmp;
  logic [IB+OUT_W-1:0] src_wide;

  logic             out_valid_r;
  logic [OUT_W-1:0] source_r;
  logic             oor_r;

  ndt_stride_seq #(
    .MAX_RANK  (MAX_RANK),
    .INDEX_BITS(INDEX_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_bus),
    .busy      (busy),
    .div_stride(div_stride),
    .coef      (coef),
    .elem_count(elem_count)
  );

  // Chain advances whenever the output register is free or being emptied.
  assign advance      = !out_valid_r || out_bus.ready;
  assign in_bus.ready = !busy && advance;

  // Head of the chain: range check and the starting remainder.
  always_comb begin
    idx_wide     = {{IB{1'b0}}, in_bus.out_index};
    idx_cmp      = (IB+IN_W+1)'(in_bus.out_index);
    cnt_cmp      = (IB+IN_W+1)'(elem_count);
    ctl[0].valid = in_bus.valid && in_bus.ready;
    ctl[0].oor   = idx_cmp >= cnt_cmp;
    rem[0]       = idx_wide[IB-1:0];
    src[0]       = '0;
  end

  // One cell per quotient bit, outer axes first, high bit first within an axis.
  for (genvar gi = 0; gi < MAX_RANK; gi++) begin : g_axis
    for (genvar gk = 0; gk < DIGITS; gk++) begin : g_bit
      localparam int J = gi * DIGITS + gk;
      ndt_cell #(
        .INDEX_BITS(INDEX_BITS),
        .SHIFT     (DIGITS - 1 - gk)
      ) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .ctl_i (ctl[J]),
        .rem_i (rem[J]),
        .src_i (src[J]),
        .stride(div_stride[gi]),
        .coef  (coef[gi]),
        .ctl_o (ctl[J+1]),
        .rem_o (rem[J+1]),
        .src_o (src[J+1])
      );
    end
  end

  assign src_wide = (IB+OUT_W)'(src[NCELLS]);

  // Output register; an out-of-range beat reports source index zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= ctl[NCELLS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      source_r <= ctl[NCELLS].oor ? '0 : src_wide[OUT_W-1:0];
      oor_r    <= ctl[NCELLS].oor;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.source_index = source_r;
  assign out_bus.out_of_range = oor_r;

endmodule

>>> design/ndt_checker.sv
// ----------------------------------------------------------------------------
// ndt_checker: port-level assertions for the transpose index generator
// Watches the three channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module ndt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_source_index,
  input logic        out_of_range,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_source_index) &&
    $stable(out_of_range))
    else $error("result beat changed while stalled");

  // An out-of-range beat always reports source index zero.
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_of_range |-> out_source_index == 32'd0)
    else $error("out-of-range beat with nonzero source index");

  // A stalled output stalls the input side in the same cycle.
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // A configuration write starts a stride sweep, which blocks input.
  a_cfg_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input ready right after a configuration write");

  // The sweep after reset blocks input.
  a_rst_sweep: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_ready)
    else $error("input ready right after reset");

endmodule

bind nd_transpose_source_index ndt_checker u_ndt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_bus.valid),
  .in_ready        (in_bus.ready),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .out_source_index(out_bus.source_index),
  .out_of_range    (out_bus.out_of_range),
  .cfg_valid       (cfg_bus.valid),
  .cfg_ready       (cfg_bus.ready)
);
